// File: hdl/ffhbt_pkg.sv
package ffhbt_pkg;

   localparam int OFFSET_BITS    = 24;
   localparam int SIZE_W         = 16;
   localparam int HEADER_BYTES   = 16;
   localparam int MAX_BLOCKS_DEF = 64;
   localparam int HEAP_END_W     = 25;
   // Wide enough for an end offset plus a header and a full size.
   localparam int SUM_W          = OFFSET_BITS + 2;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 25;

   localparam logic [SIZE_W-1:0]     FIRST_SIZE_RESET = 16'h1000;
   localparam logic [HEAP_END_W-1:0] HEAP_END_RESET   = 25'h1000000;

   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_FREE    = 2'd1;
   localparam logic [1:0] REQ_RESERVE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAP_END   = 2'd1;

   typedef enum logic [1:0] {
      ST_OK,
      ST_NO_FIT,
      ST_FULL,
      ST_PAST_END
   } status_type;

   typedef enum logic [1:0] {
      PLAN_FAIL,
      PLAN_INSERT,
      PLAN_DELETE
   } plan_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] start;
      logic [SIZE_W-1:0]      size;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       scan_rd;
      logic       scan_step;
      logic       cap_hit;
      logic       cap_end;
      logic       set_result;
      status_type result_code;
      logic       move_rd;
      logic       move_wr;
      logic       commit;
      logic       respond;
   } cmd_type;

   typedef struct packed {
      logic     bad_req;
      logic     scan_end;
      logic     hit;
      plan_type plan;
      logic     full;
      logic     over_limit;
      logic     move_done;
   } stat_type;

endpackage

// File: hdl/ffhbt_ctrl.sv
module ffhbt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  ffhbt_pkg::stat_type stat,
   output ffhbt_pkg::cmd_type  cmd,
   output logic               busy
);
   import ffhbt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_DECIDE,
      S_MOVE_RD,
      S_MOVE_WR,
      S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (stat.bad_req) begin
               cmd.set_result  = 1'b1;
               cmd.result_code = ST_NO_FIT;
               state_in        = S_RESP;
            end else if (stat.scan_end) begin
               cmd.cap_end = 1'b1;
               state_in    = S_DECIDE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: begin
            if (stat.hit) begin
               cmd.cap_hit = 1'b1;
               state_in    = S_DECIDE;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_DECIDE: begin
            cmd.set_result = 1'b1;
            unique case (stat.plan)
               PLAN_DELETE: begin
                  cmd.result_code = ST_OK;
                  state_in        = S_MOVE_RD;
               end
               PLAN_INSERT: begin
                  // A full table outranks a block that runs past the heap end.
                  if (stat.full) begin
                     cmd.result_code = ST_FULL;
                     state_in        = S_RESP;
                  end else if (stat.over_limit) begin
                     cmd.result_code = ST_PAST_END;
                     state_in        = S_RESP;
                  end else begin
                     cmd.result_code = ST_OK;
                     state_in        = S_MOVE_RD;
                  end
               end
               default: begin
                  cmd.result_code = ST_NO_FIT;
                  state_in        = S_RESP;
               end
            endcase
         end
         S_MOVE_RD: begin
            if (stat.move_done) begin
               cmd.commit = 1'b1;
               state_in   = S_RESP;
            end else begin
               cmd.move_rd = 1'b1;
               state_in    = S_MOVE_WR;
            end
         end
         S_MOVE_WR: begin
            cmd.move_wr = 1'b1;
            state_in    = S_MOVE_RD;
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

// File: hdl/ffhbt_datapath.sv
module ffhbt_datapath #(
   parameter int MAX_BLOCKS = ffhbt_pkg::MAX_BLOCKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_type,
   input  logic [ffhbt_pkg::OFFSET_BITS-1:0] req_user_addr,
   input  logic [ffhbt_pkg::SIZE_W-1:0]      req_size,
   input  logic                              csr_write,
   input  logic [ffhbt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ffhbt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  ffhbt_pkg::cmd_type                cmd,
   output ffhbt_pkg::stat_type               stat,
   output logic                              rsp_valid,
   output ffhbt_pkg::status_type             rsp_status,
   output logic [ffhbt_pkg::OFFSET_BITS-1:0] rsp_result_addr
);
   import ffhbt_pkg::*;

   localparam int IDX_W = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [SUM_W-1:0] HDR_S = SUM_W'(HEADER_BYTES);
   localparam logic [SUM_W-1:0] CAP_S = SUM_W'(1) << OFFSET_BITS;
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
   localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_BLOCKS);

   // Entry 0 always starts at offset zero and never moves, so only its size
   // is kept; the memory holds entries 1 and up.
   entry_type mem [MAX_BLOCKS];
   entry_type rd_data_ff;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SIZE_W-1:0]      e0_size_ff, e0_size_in;
   logic [HEAP_END_W-1:0]  heap_end_ff, heap_end_in;
   logic [1:0]             op_ff, op_in;
   logic [OFFSET_BITS-1:0] addr_ff, addr_in;
   logic [SIZE_W-1:0]      size_ff, size_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] prev_start_ff, prev_start_in;
   logic [SUM_W-1:0]       prev_end_ff, prev_end_in;
   logic [SUM_W-1:0]       place_hdr_ff, place_hdr_in;
   plan_type               plan_ff, plan_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [OFFSET_BITS-1:0] rsp_addr_ff, rsp_addr_in;

   logic [SUM_W-1:0]       hdr;
   logic [SUM_W-1:0]       rd_start;
   logic [SUM_W-1:0]       rd_end;
   logic [SUM_W-1:0]       alloc_need;
   logic [SUM_W-1:0]       hdr_need;
   logic [SUM_W-1:0]       place_need;
   logic [SUM_W-1:0]       placed_addr;
   logic [SUM_W-1:0]       limit;
   logic                   alloc_fit;
   logic                   between;
   logic                   gap_fit;
   logic                   free_match;
   logic                   tail_fit;
   logic [CNT_W-1:0]       idx_m1;
   logic [CNT_W-1:0]       idx_p1;
   logic [CNT_W-1:0]       cnt_m1;
   logic [CNT_W-1:0]       pos_p1_c;
   logic [IDX_W-1:0]       pos_p1;
   logic                   is_insert;
   logic                   mem_re;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_raddr;
   logic [IDX_W-1:0]       mem_waddr;
   entry_type              mem_wdata;

   assign hdr         = SUM_W'(addr_ff) - HDR_S;
   assign rd_start    = SUM_W'(rd_data_ff.start);
   assign rd_end      = rd_start + HDR_S + SUM_W'(rd_data_ff.size);
   assign alloc_need  = prev_end_ff + HDR_S + SUM_W'(size_ff);
   assign hdr_need    = hdr + HDR_S + SUM_W'(size_ff);
   assign place_need  = place_hdr_ff + HDR_S + SUM_W'(size_ff);
   assign placed_addr = place_hdr_ff + HDR_S;
   assign limit       = (SUM_W'(heap_end_ff) > CAP_S) ? CAP_S : SUM_W'(heap_end_ff);

   assign alloc_fit   = (alloc_need <= rd_start);
   assign between     = (SUM_W'(prev_start_ff) < hdr) && (hdr < rd_start);
   assign gap_fit     = (prev_end_ff <= hdr) && (hdr_need <= rd_start);
   assign free_match  = ((rd_start + HDR_S) == SUM_W'(addr_ff));
   assign tail_fit    = (prev_end_ff <= hdr);

   assign idx_m1    = idx_ff - ONE_C;
   assign idx_p1    = idx_ff + ONE_C;
   assign cnt_m1    = count_ff - ONE_C;
   assign pos_p1_c  = CNT_W'(pos_ff) + ONE_C;
   assign pos_p1    = pos_p1_c[IDX_W-1:0];
   assign is_insert = (plan_ff == PLAN_INSERT);

   // Status toward the controller.
   always_comb begin
      stat.bad_req = !((op_ff == REQ_ALLOC) || (op_ff == REQ_FREE) ||
                       ((op_ff == REQ_RESERVE) && (SUM_W'(addr_ff) >= HDR_S)));
      stat.scan_end = (idx_ff == count_ff);
      unique case (op_ff)
         REQ_ALLOC:   stat.hit = alloc_fit;
         REQ_FREE:    stat.hit = free_match;
         REQ_RESERVE: stat.hit = between;
         default:     stat.hit = 1'b0;
      endcase
      stat.plan       = plan_ff;
      stat.full       = (count_ff >= MAX_C);
      stat.over_limit = (place_need > limit);
      stat.move_done  = is_insert ? (idx_ff == pos_p1_c) : (idx_p1 == count_ff);
   end

   // Memory port control. Inserts shift entries up from the tail, deletes
   // shift them down toward the freed slot.
   always_comb begin
      mem_re = cmd.scan_rd | cmd.move_rd;
      if (cmd.scan_rd) begin
         mem_raddr = idx_ff[IDX_W-1:0];
      end else if (is_insert) begin
         mem_raddr = idx_m1[IDX_W-1:0];
      end else begin
         mem_raddr = idx_p1[IDX_W-1:0];
      end
      mem_we = cmd.move_wr | (cmd.commit & is_insert);
      if (cmd.move_wr) begin
         mem_waddr = idx_ff[IDX_W-1:0];
         mem_wdata = rd_data_ff;
      end else begin
         mem_waddr       = pos_p1;
         mem_wdata.start = place_hdr_ff[OFFSET_BITS-1:0];
         mem_wdata.size  = size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      count_in      = count_ff;
      e0_size_in    = e0_size_ff;
      heap_end_in   = heap_end_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      size_in       = size_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      prev_start_in = prev_start_ff;
      prev_end_in   = prev_end_ff;
      place_hdr_in  = place_hdr_ff;
      plan_in       = plan_ff;
      rsp_valid_in  = cmd.respond;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;

      if (csr_write) begin
         if (csr_index == CSR_FIRST_SIZE) begin
            // The first block follows the register only while it stands alone.
            if (count_ff == ONE_C) begin
               e0_size_in = csr_wdata[SIZE_W-1:0];
            end
         end else if (csr_index == CSR_HEAP_END) begin
            heap_end_in = csr_wdata[HEAP_END_W-1:0];
         end
      end

      if (cmd.load) begin
         op_in         = req_type;
         addr_in       = req_user_addr;
         size_in       = req_size;
         idx_in        = ONE_C;
         prev_start_in = '0;
         prev_end_in   = HDR_S + SUM_W'(e0_size_ff);
      end

      if (cmd.scan_step) begin
         prev_start_in = rd_data_ff.start;
         prev_end_in   = rd_end;
         idx_in        = idx_p1;
      end

      if (cmd.cap_hit) begin
         pos_in       = (op_ff == REQ_FREE) ? idx_ff[IDX_W-1:0] : idx_m1[IDX_W-1:0];
         place_hdr_in = (op_ff == REQ_ALLOC) ? prev_end_ff : hdr;
         unique case (op_ff)
            REQ_ALLOC:   plan_in = PLAN_INSERT;
            REQ_FREE:    plan_in = PLAN_DELETE;
            REQ_RESERVE: plan_in = gap_fit ? PLAN_INSERT : PLAN_FAIL;
            default:     plan_in = PLAN_FAIL;
         endcase
      end

      if (cmd.cap_end) begin
         pos_in       = cnt_m1[IDX_W-1:0];
         place_hdr_in = (op_ff == REQ_ALLOC) ? prev_end_ff : hdr;
         unique case (op_ff)
            REQ_ALLOC:   plan_in = PLAN_INSERT;
            REQ_RESERVE: plan_in = tail_fit ? PLAN_INSERT : PLAN_FAIL;
            default:     plan_in = PLAN_FAIL;
         endcase
      end

      if (cmd.set_result) begin
         rsp_status_in = cmd.result_code;
         if (cmd.result_code == ST_OK) begin
            rsp_addr_in = (plan_ff == PLAN_DELETE) ? addr_ff
                                                   : placed_addr[OFFSET_BITS-1:0];
            idx_in      = is_insert ? count_ff : CNT_W'(pos_ff);
         end else begin
            rsp_addr_in = '0;
         end
      end

      if (cmd.move_wr) begin
         idx_in = is_insert ? idx_m1 : idx_p1;
      end

      if (cmd.commit) begin
         count_in = is_insert ? (count_ff + ONE_C) : cnt_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= ONE_C;
         e0_size_ff   <= FIRST_SIZE_RESET;
         heap_end_ff  <= HEAP_END_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         e0_size_ff   <= e0_size_in;
         heap_end_ff  <= heap_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      prev_start_ff <= prev_start_in;
      prev_end_ff   <= prev_end_in;
      place_hdr_ff  <= place_hdr_in;
      plan_ff       <= plan_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_result_addr = rsp_addr_ff;

endmodule

// File: hdl/first_fit_heap_block_table_unit.sv
// Channel   Handshake                             Payload
// request   start, busy (accept: start & !busy)   req_type, req_user_addr, req_size
// response  rsp_valid (one-cycle strobe)          rsp_status, rsp_result_addr
// config    csr_valid, csr_ready                  csr_index, csr_wdata
//
// Requests run one at a time; the response strobe follows a scan that reads the entries
// in order and, for a success, the shift of the entries that move. A request failing
// after the scan skips the shift, and an unknown request or a reserve below the header
// size answers without a scan.
// Reset is synchronous and empties the table down to the first block.
// The receiver cannot stall: rsp_valid is high for one cycle; csr writes are always ready.
module first_fit_heap_block_table_unit #(
   parameter int MAX_BLOCKS = ffhbt_pkg::MAX_BLOCKS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic [ffhbt_pkg::OFFSET_BITS-1:0] req_user_addr,
   input  logic [ffhbt_pkg::SIZE_W-1:0]      req_size,
   output logic                              rsp_valid,
   output ffhbt_pkg::status_type             rsp_status,
   output logic [ffhbt_pkg::OFFSET_BITS-1:0] rsp_result_addr,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ffhbt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ffhbt_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ffhbt_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   ffhbt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   ffhbt_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_user_addr   (req_user_addr),
      .req_size        (req_size),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_result_addr (rsp_result_addr)
   );

   // A response ends its transaction, so the unit is free while it shows.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_result_addr == '0))
      else $error("failed transaction returned a nonzero address");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted transaction did not make the unit busy");

endmodule
